// File: hdl/cwpsa_pkg.sv
// Shared constants, types and helpers for the clock with periodic slot alarms.
package cwpsa_pkg;

  localparam int NUM_SLOTS_DEF = 4;
  localparam int MASK_W        = 4;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_PROG  = 2'd2;
  localparam logic [1:0] OP_SERVE = 2'd3;

  localparam logic [5:0] SEC_LAST  = 6'd59;
  localparam logic [5:0] MIN_LAST  = 6'd59;
  localparam logic [5:0] MIN_MOD   = 6'd60;
  localparam logic [4:0] HOUR_LAST = 5'd23;

  // command from the time path to the slot bank, one per item
  typedef struct packed {
    logic       en;
    logic [1:0] op;
    logic [1:0] slot;
    logic [6:0] period;
    logic [4:0] hour_cur;
    logic       min_wrap;
    logic [4:0] hour_new;
    logic [5:0] minute_new;
  } slot_cmd_t;

  typedef struct packed {
    logic [MASK_W-1:0] pending_mask;
    logic              fired;
  } slot_stat_t;

  // v <= 150: three compare/subtract steps
  function automatic logic [4:0] mod24(input logic [7:0] v);
    logic [7:0] t;
    t = v;
    if (t >= 8'd96) t = t - 8'd96;
    if (t >= 8'd48) t = t - 8'd48;
    if (t >= 8'd24) t = t - 8'd24;
    return t[4:0];
  endfunction

  function automatic logic [5:0] mod60(input logic [5:0] v);
    return (v >= MIN_MOD) ? (v - MIN_MOD) : v;
  endfunction

endpackage

// File: hdl/cwpsa_slots.sv
// Alarm slot bank: per-slot schedule, pending and armed state, match logic.
module cwpsa_slots #(
  parameter int NUM_SLOTS = cwpsa_pkg::NUM_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cwpsa_pkg::slot_cmd_t  cmd,
  output cwpsa_pkg::slot_stat_t stat
);

  logic [4:0] ah_r   [NUM_SLOTS];
  logic [5:0] am_r   [NUM_SLOTS];
  logic [6:0] per_r  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] pend_r;
  logic [NUM_SLOTS-1:0] armed_r;

  logic [NUM_SLOTS-1:0] sel;
  logic [NUM_SLOTS-1:0] match;
  logic [NUM_SLOTS-1:0] pend_nxt;
  logic [6:0]           per_sel;
  logic [6:0]           per_use;
  logic [4:0]           hour_sched;
  logic                 is_prog;
  logic                 is_serve;

  assign is_prog  = (cmd.op == cwpsa_pkg::OP_PROG);
  assign is_serve = (cmd.op == cwpsa_pkg::OP_SERVE);

  always_comb begin
    per_sel = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (sel[k]) per_sel = per_r[k];
    end
  end

  assign per_use    = is_prog ? cmd.period : per_sel;
  assign hour_sched = cwpsa_pkg::mod24({3'b000, cmd.hour_cur} + {1'b0, per_use});

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_slot
    logic prog_k;
    logic serve_k;

    // slot codes at or above NUM_SLOTS select nothing
    assign sel[k]   = (32'(cmd.slot) == k);
    assign prog_k   = is_prog && sel[k];
    assign serve_k  = is_serve && sel[k] && pend_r[k];
    assign match[k] = cmd.min_wrap && armed_r[k] &&
                      (ah_r[k] == cmd.hour_new) && (am_r[k] == cmd.minute_new);
    assign pend_nxt[k] = match[k] | prog_k | (pend_r[k] & ~serve_k);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pend_r[k]  <= 1'b0;
        armed_r[k] <= 1'b0;
      end else if (cmd.en) begin
        pend_r[k] <= pend_nxt[k];
        if (prog_k) armed_r[k] <= 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.en) begin
        if (prog_k) begin
          per_r[k] <= cmd.period;
          ah_r[k]  <= hour_sched;
          am_r[k]  <= cmd.minute_new;
        end else if (serve_k) begin
          ah_r[k]  <= hour_sched;
        end
      end
    end
  end

  for (genvar k = 0; k < cwpsa_pkg::MASK_W; k++) begin : g_mask
    if (k < NUM_SLOTS) begin : g_on
      assign stat.pending_mask[k] = pend_nxt[k];
    end else begin : g_off
      assign stat.pending_mask[k] = 1'b0;
    end
  end

  assign stat.fired = |match;

endmodule

// File: hdl/clock_with_periodic_slot_alarms.sv
// Top level: time-of-day clock with periodic alarm slots.
// A beat is captured in the input register, then processed into the output register once that is free.
// Throughput: one beat per cycle while the output is not stalled; input register, single-pass update, output register.
// A stalled output holds one result while the input register still takes one more beat.
// Reset (rst_n low, synchronous): time 00:00:00, no slot armed or pending, both regs empty.
module clock_with_periodic_slot_alarms #(
  parameter int NUM_SLOTS = cwpsa_pkg::NUM_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [1:0] in_slot,
  input  logic [6:0] in_period_hours,
  input  logic [4:0] in_new_hour,
  input  logic [5:0] in_new_minute,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_hour_now,
  output logic [5:0] out_minute_now,
  output logic [5:0] out_second_now,
  output logic [3:0] out_pending_mask,
  output logic       out_alarm_fired
);

  logic       v0_r;
  logic [1:0] op_r;
  logic [1:0] slot_r;
  logic [6:0] per_r;
  logic [4:0] nh_r;
  logic [5:0] nm_r;

  logic [5:0] sec_r,  sec_nxt;
  logic [5:0] min_r,  min_nxt;
  logic [4:0] hour_r, hour_nxt;

  logic       out_valid_r;
  logic [4:0] out_hour_r;
  logic [5:0] out_min_r;
  logic [5:0] out_sec_r;
  logic [3:0] out_mask_r;
  logic       out_fired_r;

  logic advance;
  logic is_tick;
  logic is_set;
  logic sec_wrap;
  logic min_carry;

  cwpsa_pkg::slot_cmd_t  cmd;
  cwpsa_pkg::slot_stat_t stat;

  assign advance  = v0_r && (!out_valid_r || out_ready);
  assign in_ready = !v0_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_ready) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_r   <= in_operation;
      slot_r <= in_slot;
      per_r  <= in_period_hours;
      nh_r   <= in_new_hour;
      nm_r   <= in_new_minute;
    end
  end

  // time update
  assign is_tick   = (op_r == cwpsa_pkg::OP_TICK);
  assign is_set    = (op_r == cwpsa_pkg::OP_SET);
  assign sec_wrap  = is_tick && (sec_r >= cwpsa_pkg::SEC_LAST);
  assign min_carry = sec_wrap && (min_r >= cwpsa_pkg::MIN_LAST);

  always_comb begin
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;
    if (is_tick) begin
      sec_nxt = sec_wrap ? 6'd0 : sec_r + 6'd1;
      if (sec_wrap) begin
        min_nxt = min_carry ? 6'd0 : min_r + 6'd1;
        if (min_carry) hour_nxt = (hour_r >= cwpsa_pkg::HOUR_LAST) ? 5'd0 : hour_r + 5'd1;
      end
    end else if (is_set) begin
      min_nxt  = cwpsa_pkg::mod60(nm_r);
      hour_nxt = cwpsa_pkg::mod24({3'b000, nh_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r  <= '0;
      min_r  <= '0;
      hour_r <= '0;
    end else if (advance) begin
      sec_r  <= sec_nxt;
      min_r  <= min_nxt;
      hour_r <= hour_nxt;
    end
  end

  always_comb begin
    cmd.en         = advance;
    cmd.op         = op_r;
    cmd.slot       = slot_r;
    cmd.period     = per_r;
    cmd.hour_cur   = hour_r;
    cmd.min_wrap   = sec_wrap;
    cmd.hour_new   = hour_nxt;
    cmd.minute_new = min_nxt;
  end

  cwpsa_slots #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_slots (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_hour_r  <= hour_nxt;
      out_min_r   <= min_nxt;
      out_sec_r   <= sec_nxt;
      out_mask_r  <= stat.pending_mask;
      out_fired_r <= stat.fired;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hour_now     = out_hour_r;
  assign out_minute_now   = out_min_r;
  assign out_second_now   = out_sec_r;
  assign out_pending_mask = out_mask_r;
  assign out_alarm_fired  = out_fired_r;

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sec_r <= cwpsa_pkg::SEC_LAST) && (min_r <= cwpsa_pkg::MIN_LAST) &&
    (hour_r <= cwpsa_pkg::HOUR_LAST))
    else $error("time register out of range");

  a_fire_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fired_r) |-> (out_sec_r == 6'd0))
    else $error("alarm fired without a minute wrap");

  a_hold_time: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(sec_r) && $stable(min_r) && $stable(hour_r)))
    else $error("time changed without a processed beat");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed beat produced no result");

endmodule

// File: bench/clock_with_periodic_slot_alarms_tb.sv
// Self-checking testbench for the clock with periodic slot alarms.
`timescale 1ns / 1ps

module clock_with_periodic_slot_alarms_tb;

  localparam int SLOTS            = cwpsa_pkg::NUM_SLOTS_DEF;
  localparam int HOURS_PER_DAY    = 24;
  localparam int MINUTES_PER_HOUR = 60;
  localparam int RANDOM_BEATS     = 1500;
  localparam int LONG_HOLD        = 300;
  localparam int HOLD_AT_RESULT   = 400;
  localparam int TAIL_CYCLES      = 8;
  localparam int CYCLE_LIMIT      = 400000;

  typedef struct {
    logic [1:0] op;
    logic [1:0] slot;
    logic [6:0] period;
    logic [4:0] new_hour;
    logic [5:0] new_minute;
  } beat_t;

  typedef struct {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [3:0] pending;
    logic       fired;
  } readout_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_operation = '0;
  logic [1:0] in_slot = '0;
  logic [6:0] in_period_hours = '0;
  logic [4:0] in_new_hour = '0;
  logic [5:0] in_new_minute = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [4:0] out_hour_now;
  logic [5:0] out_minute_now;
  logic [5:0] out_second_now;
  logic [3:0] out_pending_mask;
  logic       out_alarm_fired;

  clock_with_periodic_slot_alarms i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_slot          (in_slot),
    .in_period_hours  (in_period_hours),
    .in_new_hour      (in_new_hour),
    .in_new_minute    (in_new_minute),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hour_now     (out_hour_now),
    .out_minute_now   (out_minute_now),
    .out_second_now   (out_second_now),
    .out_pending_mask (out_pending_mask),
    .out_alarm_fired  (out_alarm_fired)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the clock and slot bank
  logic [5:0] sec_q;
  logic [5:0] min_q;
  logic [4:0] hour_q;
  logic [4:0] alarm_hour_q [SLOTS];
  logic [5:0] alarm_min_q  [SLOTS];
  logic [6:0] period_q     [SLOTS];
  logic       pending_q    [SLOTS];
  logic       armed_q      [SLOTS];

  beat_t    beats_to_send[$];
  readout_t expected_readouts[$];

  int beats_sent;
  int readouts_seen;
  int alarms_seen;
  int mismatches;
  int cycle_count;

  function automatic readout_t clock_update(beat_t b);
    readout_t r;
    logic     hit;
    hit = 1'b0;
    case (b.op)
      cwpsa_pkg::OP_TICK: begin
        if (sec_q >= cwpsa_pkg::SEC_LAST) begin
          sec_q = '0;
          if (min_q >= cwpsa_pkg::MIN_LAST) begin
            min_q  = '0;
            hour_q = (hour_q >= cwpsa_pkg::HOUR_LAST) ? 5'd0 : hour_q + 5'd1;
          end else begin
            min_q = min_q + 6'd1;
          end
          for (int k = 0; k < SLOTS; k++) begin
            if (armed_q[k] && alarm_hour_q[k] == hour_q && alarm_min_q[k] == min_q) begin
              pending_q[k] = 1'b1;
              hit = 1'b1;
            end
          end
        end else begin
          sec_q = sec_q + 6'd1;
        end
      end
      cwpsa_pkg::OP_SET: begin
        hour_q = 5'(int'(b.new_hour) % HOURS_PER_DAY);
        min_q  = 6'(int'(b.new_minute) % MINUTES_PER_HOUR);
      end
      cwpsa_pkg::OP_PROG: begin
        if (b.slot < SLOTS) begin
          period_q[b.slot]     = b.period;
          alarm_hour_q[b.slot] = 5'((int'(hour_q) + int'(b.period)) % HOURS_PER_DAY);
          alarm_min_q[b.slot]  = min_q;
          armed_q[b.slot]      = 1'b1;
          pending_q[b.slot]    = 1'b1;
        end
      end
      default: begin
        // serve: only the hour moves, and only for a pending slot
        if (b.slot < SLOTS && pending_q[b.slot]) begin
          alarm_hour_q[b.slot] = 5'((int'(hour_q) + int'(period_q[b.slot])) % HOURS_PER_DAY);
          pending_q[b.slot]    = 1'b0;
        end
      end
    endcase
    r.hour    = hour_q;
    r.minute  = min_q;
    r.second  = sec_q;
    r.pending = '0;
    for (int k = 0; k < SLOTS && k < 4; k++) r.pending[k] = pending_q[k];
    r.fired   = hit;
    return r;
  endfunction

  task automatic queue_beat(logic [1:0] op, logic [1:0] slot, logic [6:0] period,
                            logic [4:0] nh, logic [5:0] nm);
    beat_t b;
    b.op         = op;
    b.slot       = slot;
    b.period     = period;
    b.new_hour   = nh;
    b.new_minute = nm;
    beats_to_send.push_back(b);
  endtask

  // alarm scenario: set the time, program slots, jump to one minute before
  // the alarm and tick through the minute wrap
  task automatic queue_alarm_run(int h, int m, int force_period);
    int p;
    int th;
    int ph;
    int pm;
    int n;
    queue_beat(cwpsa_pkg::OP_SET, 2'($urandom_range(0, 3)), 7'($urandom), 5'(h), 6'(m));
    n = $urandom_range(1, 4);
    p = 0;
    for (int i = 0; i < n; i++) begin
      if (force_period >= 0) p = force_period;
      else if ($urandom_range(0, 4) == 0) p = $urandom_range(100, 127);
      else p = $urandom_range(0, 99);
      queue_beat(cwpsa_pkg::OP_PROG, 2'($urandom_range(0, 3)), 7'(p), 5'($urandom),
                 6'($urandom));
    end
    if ($urandom_range(0, 2) == 0)
      queue_beat(cwpsa_pkg::OP_SERVE, 2'($urandom_range(0, 3)), 7'($urandom), 5'($urandom),
                 6'($urandom));
    th = (h + p) % HOURS_PER_DAY;
    if (m == 0) begin
      pm = MINUTES_PER_HOUR - 1;
      ph = (th + HOURS_PER_DAY - 1) % HOURS_PER_DAY;
    end else begin
      pm = m - 1;
      ph = th;
    end
    queue_beat(cwpsa_pkg::OP_SET, 2'($urandom_range(0, 3)), 7'($urandom), 5'(ph), 6'(pm));
    // 60 to 64 ticks cross at least one wrap whatever the seconds were
    n = MINUTES_PER_HOUR + $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0)
        queue_beat(cwpsa_pkg::OP_SERVE, 2'($urandom_range(0, 3)), 7'($urandom), 5'($urandom),
                   6'($urandom));
      queue_beat(cwpsa_pkg::OP_TICK, 2'($urandom), 7'($urandom), 5'($urandom), 6'($urandom));
    end
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++)
      queue_beat(cwpsa_pkg::OP_SERVE, 2'($urandom_range(0, 3)), 7'($urandom), 5'($urandom),
                 6'($urandom));
  endtask

  initial begin
    int target;
    int n;
    for (int k = 0; k < SLOTS; k++) begin
      alarm_hour_q[k] = '0;
      alarm_min_q[k]  = '0;
      period_q[k]     = '0;
      pending_q[k]    = 1'b0;
      armed_q[k]      = 1'b0;
    end
    sec_q  = '0;
    min_q  = '0;
    hour_q = '0;

    // directed: field extremes, every operation, the corner cases
    queue_beat(cwpsa_pkg::OP_TICK,  2'd0, 7'd0,   5'd0,  6'd0);
    queue_beat(cwpsa_pkg::OP_SET,   2'd3, 7'd127, 5'd31, 6'd63);  // both reduced
    queue_beat(cwpsa_pkg::OP_SET,   2'd0, 7'd0,   5'd23, 6'd59);
    queue_beat(cwpsa_pkg::OP_SERVE, 2'd2, 7'd5,   5'd0,  6'd0);   // not pending yet
    queue_beat(cwpsa_pkg::OP_PROG,  2'd0, 7'd0,   5'd0,  6'd0);
    queue_beat(cwpsa_pkg::OP_PROG,  2'd1, 7'd127, 5'd31, 6'd63);  // period beyond 99
    queue_beat(cwpsa_pkg::OP_PROG,  2'd2, 7'd99,  5'd0,  6'd0);
    queue_beat(cwpsa_pkg::OP_PROG,  2'd3, 7'd24,  5'd0,  6'd0);
    queue_beat(cwpsa_pkg::OP_SERVE, 2'd0, 7'd0,   5'd0,  6'd0);
    queue_beat(cwpsa_pkg::OP_SERVE, 2'd0, 7'd0,   5'd0,  6'd0);   // already served
    queue_beat(cwpsa_pkg::OP_SET,   2'd1, 7'd0,   5'd0,  6'd0);
    queue_beat(cwpsa_pkg::OP_SERVE, 2'd1, 7'd0,   5'd0,  6'd0);   // minute must stay
    queue_beat(cwpsa_pkg::OP_PROG,  2'd3, 7'd100, 5'd0,  6'd0);
    queue_beat(cwpsa_pkg::OP_SET,   2'd2, 7'd64,  5'd24, 6'd60);
    queue_beat(cwpsa_pkg::OP_TICK,  2'd3, 7'd127, 5'd31, 6'd63);
    queue_beat(cwpsa_pkg::OP_SERVE, 2'd2, 7'd0,   5'd0,  6'd0);
    queue_beat(cwpsa_pkg::OP_SERVE, 2'd3, 7'd0,   5'd0,  6'd0);
    queue_beat(cwpsa_pkg::OP_SET,   2'd0, 7'd0,   5'd12, 6'd30);

    target = beats_to_send.size() + RANDOM_BEATS;
    // first run lands on midnight so the hour wraps through 23:59
    queue_alarm_run(0, 0, HOURS_PER_DAY);
    while (beats_to_send.size() < target) begin
      if ($urandom_range(0, 9) < 7) begin
        queue_alarm_run($urandom_range(0, 23), $urandom_range(0, 59), -1);
      end else begin
        n = $urandom_range(5, 30);
        for (int i = 0; i < n; i++)
          queue_beat(2'($urandom), 2'($urandom), 7'($urandom), 5'($urandom), 6'($urandom));
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    wait (rst_n && beats_to_send.size() == 0 && !in_valid && expected_readouts.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run drove %0d beats (ticks, clock sets, slot programs and serves) and checked %0d",
             beats_sent, readouts_seen);
    $display("results, %0d of them with an alarm firing; %0d mismatches.", alarms_seen,
             mismatches);
    if (mismatches == 0 && expected_readouts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // sender
  int    in_gap;
  bit    in_burst;
  beat_t drv_beat;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
      in_burst <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        drv_beat.op         = in_operation;
        drv_beat.slot       = in_slot;
        drv_beat.period     = in_period_hours;
        drv_beat.new_hour   = in_new_hour;
        drv_beat.new_minute = in_new_minute;
        expected_readouts.push_back(clock_update(drv_beat));
        beats_sent++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (beats_to_send.size() != 0) begin
          drv_beat = beats_to_send.pop_front();
          in_valid        <= 1'b1;
          in_operation    <= drv_beat.op;
          in_slot         <= drv_beat.slot;
          in_period_hours <= drv_beat.period;
          in_new_hour     <= drv_beat.new_hour;
          in_new_minute   <= drv_beat.new_minute;
          in_gap          <= in_burst ? 0 : $urandom_range(0, 19);
          if ($urandom_range(0, 59) == 0) in_burst <= !in_burst;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  int       out_wait;
  int       mon_next_wait;
  bit       out_burst;
  readout_t mon_want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_wait  <= 0;
      out_burst <= 1'b0;
    end else begin
      mon_next_wait = out_wait;
      if (out_valid && out_ready) begin
        readouts_seen++;
        if (out_alarm_fired) alarms_seen++;
        if (expected_readouts.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          mon_want = expected_readouts.pop_front();
          if (out_hour_now !== mon_want.hour) begin
            $error("hour_now: expected %0d, actual %0d", mon_want.hour, out_hour_now);
            mismatches++;
          end
          if (out_minute_now !== mon_want.minute) begin
            $error("minute_now: expected %0d, actual %0d", mon_want.minute, out_minute_now);
            mismatches++;
          end
          if (out_second_now !== mon_want.second) begin
            $error("second_now: expected %0d, actual %0d", mon_want.second, out_second_now);
            mismatches++;
          end
          if (out_pending_mask !== mon_want.pending) begin
            $error("pending_mask: expected %0h, actual %0h", mon_want.pending,
                   out_pending_mask);
            mismatches++;
          end
          if (out_alarm_fired !== mon_want.fired) begin
            $error("alarm_fired: expected %0d, actual %0d", mon_want.fired, out_alarm_fired);
            mismatches++;
          end
        end
        // one long hold so the input side backs up
        if (readouts_seen == HOLD_AT_RESULT) mon_next_wait = LONG_HOLD;
        else mon_next_wait = out_burst ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 59) == 0) out_burst <= !out_burst;
      end
      if (mon_next_wait > 0) begin
        out_ready <= 1'b0;
        out_wait  <= mon_next_wait - 1;
      end else begin
        out_ready <= 1'b1;
        out_wait  <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

// File: filelist.f
hdl/cwpsa_pkg.sv
hdl/cwpsa_slots.sv
hdl/clock_with_periodic_slot_alarms.sv
bench/clock_with_periodic_slot_alarms_tb.sv
